// File: rtl/cbm_pkg.sv
// Shared types and codes for the cartridge bank mapper.
// Used by the top level, the mapping core and the port checker; no dependencies.
package cbm_pkg;

   // bus access kinds
   localparam logic [1:0] ACT_CPU_READ  = 2'd0;
   localparam logic [1:0] ACT_CPU_WRITE = 2'd1;
   localparam logic [1:0] ACT_PIC_READ  = 2'd2;
   localparam logic [1:0] ACT_PIC_WRITE = 2'd3;

   // result targets
   localparam logic [2:0] TGT_NONE     = 3'd0;
   localparam logic [2:0] TGT_PRG_ROM  = 3'd1;
   localparam logic [2:0] TGT_SAVE_RAM = 3'd2;
   localparam logic [2:0] TGT_CHR_ROM  = 3'd3;
   localparam logic [2:0] TGT_CHR_RAM  = 3'd4;

   // mirroring codes
   localparam logic [2:0] MIR_HORIZONTAL   = 3'd0;
   localparam logic [2:0] MIR_VERTICAL     = 3'd1;
   localparam logic [2:0] MIR_FOUR_SCREEN  = 3'd2;
   localparam logic [2:0] MIR_SINGLE_LOWER = 3'd3;
   localparam logic [2:0] MIR_SINGLE_UPPER = 3'd4;

   // mapper kinds
   localparam logic [1:0] KIND_FIXED  = 2'd0;
   localparam logic [1:0] KIND_SERIAL = 2'd1;
   localparam logic [1:0] KIND_SWITCH = 2'd2;

   // serial mapper program modes with a fixed 16KiB half
   localparam logic [1:0] PRG_MODE_FIX_LOW  = 2'd2;
   localparam logic [1:0] PRG_MODE_FIX_HIGH = 2'd3;

   // serial mapper register selects, address bits 14:13
   localparam logic [1:0] SREG_CONTROL  = 2'd0;
   localparam logic [1:0] SREG_CHR_LOW  = 2'd1;
   localparam logic [1:0] SREG_CHR_HIGH = 2'd2;
   localparam logic [1:0] SREG_PRG      = 2'd3;

   // configuration register indexes
   localparam logic [2:0] CSR_MAPPER_KIND    = 3'd0;
   localparam logic [2:0] CSR_PRG_BANK_COUNT = 3'd1;
   localparam logic [2:0] CSR_CHR_BANK_COUNT = 3'd2;
   localparam logic [2:0] CSR_BASE_MIRRORING = 3'd3;
   localparam logic [2:0] CSR_HAS_SAVE_RAM   = 3'd4;

   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [7:0] PRG_COUNT_HIGH_BANK = 8'd32;
   localparam logic [7:0] PRG_FIXED_LIMIT     = 8'd16;

   typedef struct packed {
      logic [1:0] action;
      logic [15:0] address;
      logic [7:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0] target;
      logic store_enable;
      logic [7:0] bank;
      logic [13:0] offset;
      logic [7:0] store_data;
      logic [2:0] mirroring;
   } rsp_type;

   typedef struct packed {
      logic [1:0] mapper_kind;
      logic [7:0] prg_bank_count;
      logic [7:0] chr_bank_count;
      logic [1:0] base_mirroring;
      logic has_save_ram;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic [2:0] value;
   } mirror_load_type;

   // header mirroring 3 is taken as four-screen
   function automatic logic [2:0] clamp_mirror(input logic [1:0] m);
      return (m == 2'd3) ? MIR_FOUR_SCREEN : {1'b0, m};
   endfunction

endpackage

// File: rtl/cbm_core.sv
// Mapping core: mapper state registers and the per-word address decode.
// Depends on cbm_pkg.
module cbm_core
   import cbm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  mirror_load_type mirror_load,
   input  req_type         req_data,
   input  logic            req_fire,
   output rsp_type         rsp_next
);

   logic [4:0] shift_ff, shift_in;
   logic [2:0] count_ff, count_in;
   logic [1:0] prg_mode_ff, prg_mode_in;
   logic       chr4k_ff, chr4k_in;
   logic [7:0] prg_bank_ff, prg_bank_in;
   logic [4:0] chr_low_ff, chr_low_in;
   logic [4:0] chr_high_ff, chr_high_in;
   logic [2:0] mirror_ff, mirror_in;

   logic       serial;
   logic       upper;
   logic [3:0] fixed_bank;
   logic [7:0] last_bank;
   logic [7:0] prg_bank;

   assign serial = (cfg.mapper_kind == KIND_SERIAL);
   assign upper  = req_data.address[14];
   assign last_bank = (cfg.prg_bank_count == 8'd0) ? 8'd0 : cfg.prg_bank_count - 8'd1;
   assign fixed_bank = (cfg.prg_bank_count >= PRG_FIXED_LIMIT) ? 4'd15 :
                       (cfg.prg_bank_count == 8'd0) ? 4'd0 :
                       cfg.prg_bank_count[3:0] - 4'd1;

   always_comb begin
      prg_bank = 8'd0;
      case (cfg.mapper_kind)
         KIND_SERIAL: begin
            if (!prg_mode_ff[1]) begin
               prg_bank = {3'd0, prg_bank_ff[4:1], upper};
            end else if (prg_mode_ff == PRG_MODE_FIX_LOW) begin
               prg_bank = upper ? prg_bank_ff : {3'd0, prg_bank_ff[4], 4'd0};
            end else begin
               prg_bank = upper ? {3'd0, prg_bank_ff[4], fixed_bank} : prg_bank_ff;
            end
         end
         KIND_SWITCH: begin
            prg_bank = upper ? last_bank : prg_bank_ff;
         end
         default: begin
            prg_bank = (upper && cfg.prg_bank_count != 8'd1) ? 8'd1 : 8'd0;
         end
      endcase
   end

   // state update
   always_comb begin
      logic [4:0] s;
      logic [4:0] s_eff;
      logic [2:0] cnt;
      shift_in    = shift_ff;
      count_in    = count_ff;
      prg_mode_in = prg_mode_ff;
      chr4k_in    = chr4k_ff;
      prg_bank_in = prg_bank_ff;
      chr_low_in  = chr_low_ff;
      chr_high_in = chr_high_ff;
      mirror_in   = mirror_ff;
      s     = {req_data.value[0], shift_ff[4:1]};
      s_eff = s;
      cnt   = count_ff + 3'd1;
      if (mirror_load.load) begin
         mirror_in = mirror_load.value;
      end else if (req_fire && req_data.action == ACT_CPU_WRITE && req_data.address[15]) begin
         if (serial) begin
            if (req_data.value[7]) begin
               shift_in    = 5'd0;
               count_in    = 3'd0;
               prg_mode_in = PRG_MODE_FIX_HIGH;
            end else if (cnt < 3'd5) begin
               shift_in = s;
               count_in = cnt;
            end else begin
               shift_in = 5'd0;
               count_in = 3'd0;
               case (req_data.address[14:13])
                  SREG_CONTROL: begin
                     case (s[1:0])
                        2'd0:    mirror_in = MIR_SINGLE_LOWER;
                        2'd1:    mirror_in = MIR_SINGLE_UPPER;
                        2'd2:    mirror_in = MIR_VERTICAL;
                        default: mirror_in = MIR_HORIZONTAL;
                     endcase
                     prg_mode_in = s[3:2];
                     chr4k_in    = s[4];
                  end
                  SREG_CHR_LOW: begin
                     s_eff = chr4k_ff ? s : {s[4:1], 1'b0};
                     chr_low_in = s_eff;
                     // the high program bank bit rides on this register for 512KiB parts
                     if (s_eff[4] && cfg.prg_bank_count == PRG_COUNT_HIGH_BANK) begin
                        prg_bank_in = prg_bank_ff | 8'h10;
                     end else begin
                        prg_bank_in = prg_bank_ff & 8'hEF;
                     end
                  end
                  SREG_CHR_HIGH: begin
                     if (chr4k_ff) begin
                        chr_high_in = s;
                     end
                  end
                  default: begin
                     s_eff = prg_mode_ff[1] ? s : {s[4:1], 1'b0};
                     prg_bank_in = {3'd0, prg_bank_ff[4], s_eff[3:0]};
                  end
               endcase
            end
         end else if (cfg.mapper_kind == KIND_SWITCH) begin
            prg_bank_in = (req_data.value >= cfg.prg_bank_count) ? last_bank : req_data.value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff    <= 5'd0;
         count_ff    <= 3'd0;
         prg_mode_ff <= PRG_MODE_FIX_HIGH;
         chr4k_ff    <= 1'b0;
         prg_bank_ff <= 8'd0;
         chr_low_ff  <= 5'd0;
         chr_high_ff <= 5'd0;
         mirror_ff   <= MIR_HORIZONTAL;
      end else begin
         shift_ff    <= shift_in;
         count_ff    <= count_in;
         prg_mode_ff <= prg_mode_in;
         chr4k_ff    <= chr4k_in;
         prg_bank_ff <= prg_bank_in;
         chr_low_ff  <= chr_low_in;
         chr_high_ff <= chr_high_in;
         mirror_ff   <= mirror_in;
      end
   end

   // result word
   always_comb begin
      rsp_next = '0;
      if (req_data.action == ACT_CPU_READ || req_data.action == ACT_CPU_WRITE) begin
         if (!req_data.address[15]) begin
            if (cfg.has_save_ram) begin
               rsp_next.target = TGT_SAVE_RAM;
               rsp_next.offset = {1'b0, req_data.address[12:0]};
               if (req_data.action == ACT_CPU_WRITE) begin
                  rsp_next.store_enable = 1'b1;
                  rsp_next.store_data   = req_data.value;
               end
            end
         end else if (req_data.action == ACT_CPU_READ) begin
            rsp_next.target = TGT_PRG_ROM;
            rsp_next.bank   = prg_bank;
            rsp_next.offset = req_data.address[13:0];
         end
      end else if (cfg.chr_bank_count == 8'd0) begin
         rsp_next.target = TGT_CHR_RAM;
         rsp_next.offset = {1'b0, req_data.address[12:0]};
         if (req_data.action == ACT_PIC_WRITE) begin
            rsp_next.store_enable = 1'b1;
            rsp_next.store_data   = req_data.value;
         end
      end else if (req_data.action == ACT_PIC_READ) begin
         rsp_next.target = TGT_CHR_ROM;
         if (serial) begin
            if (chr4k_ff) begin
               rsp_next.bank = {3'd0, req_data.address[12] ? chr_high_ff : chr_low_ff};
            end else begin
               rsp_next.bank = {3'd0, chr_low_ff} + {7'd0, req_data.address[12]};
            end
            rsp_next.offset = {2'd0, req_data.address[11:0]};
         end else begin
            rsp_next.offset = {1'b0, req_data.address[12:0]};
         end
      end
      // a control write shows its new mirroring in its own result
      rsp_next.mirroring = serial ? mirror_in : clamp_mirror(cfg.base_mirroring);
   end

endmodule

// File: rtl/cartridge_bank_mapper.sv
// An accepted word's result is registered in the output register, or in the skid entry while the output stalls.
// Throughput: one word every cycle while req_ready is high, set by the single decode stage and the result register.
// A two-entry result buffer keeps req_ready high for one more word while rsp_ready is low.
// Reset (synchronous, active high) loads the configuration defaults and mapper state
// and empties the result buffer.
// Top level of the cartridge bank mapper: configuration port, result buffer.
// Depends on cbm_pkg and cbm_core.
module cartridge_bank_mapper
   import cbm_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_data,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   cfg_type         cfg_ff, cfg_in;
   mirror_load_type mirror_load;
   rsp_type         rsp_next;
   rsp_type         out_ff, skid_ff;
   logic            out_valid_ff, skid_valid_ff;
   logic            csr_write;
   logic [2:0]      csr_index;
   logic            push, pop;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      mirror_load = '0;
      if (csr_write) begin
         case (csr_index)
            CSR_MAPPER_KIND:    cfg_in.mapper_kind = csr_pwdata[1:0];
            CSR_PRG_BANK_COUNT: cfg_in.prg_bank_count = csr_pwdata[7:0];
            CSR_CHR_BANK_COUNT: cfg_in.chr_bank_count = csr_pwdata[7:0];
            CSR_BASE_MIRRORING: begin
               cfg_in.base_mirroring = csr_pwdata[1:0];
               mirror_load.load  = 1'b1;
               mirror_load.value = clamp_mirror(csr_pwdata[1:0]);
            end
            CSR_HAS_SAVE_RAM:   cfg_in.has_save_ram = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_MAPPER_KIND:    csr_prdata = {30'd0, cfg_ff.mapper_kind};
         CSR_PRG_BANK_COUNT: csr_prdata = {24'd0, cfg_ff.prg_bank_count};
         CSR_CHR_BANK_COUNT: csr_prdata = {24'd0, cfg_ff.chr_bank_count};
         CSR_BASE_MIRRORING: csr_prdata = {30'd0, cfg_ff.base_mirroring};
         CSR_HAS_SAVE_RAM:   csr_prdata = {31'd0, cfg_ff.has_save_ram};
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mapper_kind    <= KIND_FIXED;
         cfg_ff.prg_bank_count <= 8'd2;
         cfg_ff.chr_bank_count <= 8'd1;
         cfg_ff.base_mirroring <= 2'd0;
         cfg_ff.has_save_ram   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_ready = !skid_valid_ff;
   assign push      = req_valid && req_ready;
   assign pop       = out_valid_ff && rsp_ready;

   cbm_core u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .mirror_load (mirror_load),
      .req_data    (req_data),
      .req_fire    (push),
      .rsp_next    (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (!out_valid_ff || pop) begin
            out_valid_ff <= skid_valid_ff || push;
         end
         if (skid_valid_ff && pop) begin
            skid_valid_ff <= 1'b0;
         end else if (push && out_valid_ff && !pop) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   // payload: refill from the skid word first, else take the new word
   always_ff @(posedge clock) begin
      if (!out_valid_ff || pop) begin
         out_ff <= skid_valid_ff ? skid_ff : rsp_next;
      end
      if (push && out_valid_ff && !pop) begin
         skid_ff <= rsp_next;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// File: rtl/cbm_checker.sv
// Port-level checks for the cartridge bank mapper, bound to the top level.
// Depends on cbm_pkg.
module cbm_checker
   import cbm_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // hold a stalled result word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed or dropped");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.target == TGT_NONE |->
         !rsp_data.store_enable && rsp_data.bank == 8'd0 &&
         rsp_data.offset == 14'd0 && rsp_data.store_data == 8'd0)
      else $error("unmapped access carries bank, offset or data");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.store_enable |->
         rsp_data.target == TGT_SAVE_RAM || rsp_data.target == TGT_CHR_RAM)
      else $error("store to a read-only or absent target");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.store_enable |-> rsp_data.store_data == 8'd0)
      else $error("store data without store enable");

endmodule

bind cartridge_bank_mapper cbm_checker u_cbm_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
